>>> design/rocr_pkg.sv
package rocr_pkg;

    // Relay modes
    localparam logic [1:0] MODE_NORMAL       = 2'd0;
    localparam logic [1:0] MODE_CLEARING     = 2'd1;
    localparam logic [1:0] MODE_WAIT_RECLOSE = 2'd2;
    localparam logic [1:0] MODE_LOCKOUT      = 2'd3;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CURRENT_LIMIT       = 3'd0;
    localparam logic [2:0] REG_CLEARING_TICKS      = 3'd1;
    localparam logic [2:0] REG_FIRST_RECLOSE_TICKS = 3'd2;
    localparam logic [2:0] REG_LATER_RECLOSE_TICKS = 3'd3;
    localparam logic [2:0] REG_MAX_ATTEMPTS        = 3'd4;
    localparam logic [2:0] REG_ATTEMPT_RESET_TICKS = 3'd5;

    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned SINCE_W = 17;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [SINCE_W-1:0] SINCE_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [LEVEL_W-1:0] LIMIT_RESET = '1;

    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SINCE_W-1:0] since_t;

endpackage

>>> design/reclosing_overcurrent_relay.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// input     | in_valid / in_ready          | current_level
// result    | out_valid / out_ready        | breaker_open, trip_event, reclose_event,
//           |                              | over_limit, locked_out, attempts_used
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One request per cycle while in_ready is high; its result is registered in the output register as it is accepted.
// The relay state and the result register update together in a single pass.
// in_ready stays high while the output register is empty or is being drained.
// Reset (rst_n low) puts the breaker closed, timers at zero, the attempt count at zero,
// the since-reclose counter saturated and the configuration at its reset values.
module reclosing_overcurrent_relay (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rocr_pkg::LEVEL_W-1:0]          current_level,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  breaker_open,
    output logic                                  trip_event,
    output logic                                  reclose_event,
    output logic                                  over_limit,
    output logic                                  locked_out,
    output logic [rocr_pkg::COUNT_W-1:0]          attempts_used,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rocr_pkg::ADDR_W-1:0]           paddr,
    input  logic [rocr_pkg::DATA_W-1:0]           pwdata,
    output logic [rocr_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    // Configuration
    logic [rocr_pkg::LEVEL_W-1:0] current_limit_reg;
    rocr_pkg::tick_t              clearing_ticks_reg;
    rocr_pkg::tick_t              first_reclose_ticks_reg;
    rocr_pkg::tick_t              later_reclose_ticks_reg;
    rocr_pkg::count_t             max_attempts_reg;
    rocr_pkg::tick_t              attempt_reset_ticks_reg;

    // Relay state
    logic [1:0]        mode_reg;
    logic [1:0]        mode_next;
    rocr_pkg::tick_t   timer_reg;
    rocr_pkg::tick_t   timer_next;
    rocr_pkg::count_t  count_reg;
    rocr_pkg::count_t  count_next;
    rocr_pkg::since_t  since_reg;
    rocr_pkg::since_t  since_next;

    // Result register
    logic              out_valid_reg;
    logic              breaker_open_reg;
    logic              trip_event_reg;
    logic              reclose_event_reg;
    logic              over_limit_reg;
    logic              locked_out_reg;
    rocr_pkg::count_t  attempts_used_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;
    logic       accept;
    logic       over;
    logic       start_req;
    logic       trip_req;
    logic       reclose;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[rocr_pkg::ADDR_W-1:2];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_limit_reg       <= rocr_pkg::LIMIT_RESET;
            clearing_ticks_reg      <= '0;
            first_reclose_ticks_reg <= '0;
            later_reclose_ticks_reg <= '0;
            max_attempts_reg        <= '0;
            attempt_reset_ticks_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rocr_pkg::REG_CURRENT_LIMIT:
                    current_limit_reg <= pwdata[rocr_pkg::LEVEL_W-1:0];
                rocr_pkg::REG_CLEARING_TICKS:
                    clearing_ticks_reg <= pwdata[rocr_pkg::TICK_W-1:0];
                rocr_pkg::REG_FIRST_RECLOSE_TICKS:
                    first_reclose_ticks_reg <= pwdata[rocr_pkg::TICK_W-1:0];
                rocr_pkg::REG_LATER_RECLOSE_TICKS:
                    later_reclose_ticks_reg <= pwdata[rocr_pkg::TICK_W-1:0];
                rocr_pkg::REG_MAX_ATTEMPTS:
                    max_attempts_reg <= pwdata[rocr_pkg::COUNT_W-1:0];
                rocr_pkg::REG_ATTEMPT_RESET_TICKS:
                    attempt_reset_ticks_reg <= pwdata[rocr_pkg::TICK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            rocr_pkg::REG_CURRENT_LIMIT:
                prdata = {{(rocr_pkg::DATA_W-rocr_pkg::LEVEL_W){1'b0}}, current_limit_reg};
            rocr_pkg::REG_CLEARING_TICKS:
                prdata = {{(rocr_pkg::DATA_W-rocr_pkg::TICK_W){1'b0}}, clearing_ticks_reg};
            rocr_pkg::REG_FIRST_RECLOSE_TICKS:
                prdata = {{(rocr_pkg::DATA_W-rocr_pkg::TICK_W){1'b0}}, first_reclose_ticks_reg};
            rocr_pkg::REG_LATER_RECLOSE_TICKS:
                prdata = {{(rocr_pkg::DATA_W-rocr_pkg::TICK_W){1'b0}}, later_reclose_ticks_reg};
            rocr_pkg::REG_MAX_ATTEMPTS:
                prdata = {{(rocr_pkg::DATA_W-rocr_pkg::COUNT_W){1'b0}}, max_attempts_reg};
            rocr_pkg::REG_ATTEMPT_RESET_TICKS:
                prdata = {{(rocr_pkg::DATA_W-rocr_pkg::TICK_W){1'b0}}, attempt_reset_ticks_reg};
            default:
                prdata = '0;
        endcase
    end

    assign over = (current_level >= current_limit_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        since_next = (since_reg != rocr_pkg::SINCE_MAX) ? since_reg + 1'b1 : since_reg;
        start_req  = 1'b0;
        trip_req   = 1'b0;
        reclose    = 1'b0;

        case (mode_reg)
            rocr_pkg::MODE_NORMAL:
            begin
                start_req = over;
            end
            rocr_pkg::MODE_CLEARING:
            begin
                if (timer_reg > rocr_pkg::tick_t'(1))
                    timer_next = timer_reg - 1'b1;
                else if (over)
                    trip_req = 1'b1;
                else
                begin
                    mode_next  = rocr_pkg::MODE_NORMAL;
                    timer_next = '0;
                end
            end
            rocr_pkg::MODE_WAIT_RECLOSE:
            begin
                if (timer_reg > rocr_pkg::tick_t'(1))
                    timer_next = timer_reg - 1'b1;
                else
                begin
                    reclose    = 1'b1;
                    if (count_reg != rocr_pkg::COUNT_MAX)
                        count_next = count_reg + 1'b1;
                    since_next = '0;
                    mode_next  = rocr_pkg::MODE_NORMAL;
                    timer_next = '0;
                    start_req  = over;
                end
            end
            default:
                ;
        endcase

        // Zero clearing time trips on the spot, otherwise arm the clearing timer
        if (start_req)
        begin
            if (clearing_ticks_reg == '0)
                trip_req = 1'b1;
            else
            begin
                mode_next  = rocr_pkg::MODE_CLEARING;
                timer_next = clearing_ticks_reg;
            end
        end

        if (trip_req)
        begin
            // Drop the attempt count after a long enough quiet spell
            if (since_next > {1'b0, attempt_reset_ticks_reg})
                count_next = '0;
            if (count_next < max_attempts_reg)
            begin
                mode_next  = rocr_pkg::MODE_WAIT_RECLOSE;
                timer_next = (count_next == '0) ? first_reclose_ticks_reg
                                                : later_reclose_ticks_reg;
            end
            else
            begin
                mode_next  = rocr_pkg::MODE_LOCKOUT;
                timer_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rocr_pkg::MODE_NORMAL;
            timer_reg     <= '0;
            count_reg     <= '0;
            since_reg     <= rocr_pkg::SINCE_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                timer_reg <= timer_next;
                count_reg <= count_next;
                since_reg <= since_next;
            end
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            breaker_open_reg  <= (mode_next == rocr_pkg::MODE_WAIT_RECLOSE) ||
                                 (mode_next == rocr_pkg::MODE_LOCKOUT);
            trip_event_reg    <= trip_req;
            reclose_event_reg <= reclose;
            over_limit_reg    <= (mode_next == rocr_pkg::MODE_CLEARING);
            locked_out_reg    <= (mode_next == rocr_pkg::MODE_LOCKOUT);
            attempts_used_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign breaker_open  = breaker_open_reg;
    assign trip_event    = trip_event_reg;
    assign reclose_event = reclose_event_reg;
    assign over_limit    = over_limit_reg;
    assign locked_out    = locked_out_reg;
    assign attempts_used = attempts_used_reg;

`ifndef SYNTHESIS
    a_lockout_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == rocr_pkg::MODE_LOCKOUT) |=> (mode_reg == rocr_pkg::MODE_LOCKOUT))
        else $error("relay left lockout");

    a_trip_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && trip_event) |-> breaker_open)
        else $error("trip reported with breaker closed");

    a_clearing_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && over_limit) |-> (!breaker_open && !trip_event))
        else $error("clearing timer reported while open or tripping");

    a_lockout_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && locked_out) |-> breaker_open)
        else $error("lockout reported with breaker closed");
`endif

endmodule

>>> test/reclosing_overcurrent_relay_test.sv
module reclosing_overcurrent_relay_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 800_000;

    typedef logic [rocr_pkg::LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic             breaker_open;
        logic             trip_event;
        logic             reclose_event;
        logic             over_limit;
        logic             locked_out;
        rocr_pkg::count_t attempts_used;
    } relay_result_t;

    typedef struct packed {
        logic [1:0]       mode;
        rocr_pkg::tick_t  timer;
        rocr_pkg::count_t count;
        rocr_pkg::since_t since;
    } relay_state_t;

    class relay_scoreboard;
        level_t           limit;
        rocr_pkg::tick_t  clearing_len;
        rocr_pkg::tick_t  first_delay;
        rocr_pkg::tick_t  later_delay;
        rocr_pkg::count_t attempt_cap;
        rocr_pkg::tick_t  reset_window;
        relay_state_t     relay;
        relay_result_t    pending_q[$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      trips;
        int unsigned      recloses;
        int unsigned      lockout_ticks;

        function new();
            limit        = rocr_pkg::LIMIT_RESET;
            clearing_len = '0;
            first_delay  = '0;
            later_delay  = '0;
            attempt_cap  = '0;
            reset_window = '0;
            relay.mode   = rocr_pkg::MODE_NORMAL;
            relay.timer  = '0;
            relay.count  = '0;
            relay.since  = rocr_pkg::SINCE_MAX;
            errors        = 0;
            checked       = 0;
            trips         = 0;
            recloses      = 0;
            lockout_ticks = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [rocr_pkg::DATA_W-1:0] value);
            case (idx)
                rocr_pkg::REG_CURRENT_LIMIT:
                    limit        = value[rocr_pkg::LEVEL_W-1:0];
                rocr_pkg::REG_CLEARING_TICKS:
                    clearing_len = value[rocr_pkg::TICK_W-1:0];
                rocr_pkg::REG_FIRST_RECLOSE_TICKS:
                    first_delay  = value[rocr_pkg::TICK_W-1:0];
                rocr_pkg::REG_LATER_RECLOSE_TICKS:
                    later_delay  = value[rocr_pkg::TICK_W-1:0];
                rocr_pkg::REG_MAX_ATTEMPTS:
                    attempt_cap  = value[rocr_pkg::COUNT_W-1:0];
                rocr_pkg::REG_ATTEMPT_RESET_TICKS:
                    reset_window = value[rocr_pkg::TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void trip_now(inout relay_state_t s);
            // a quiet stretch since the last reclose starts a fresh sequence
            if (s.since > {1'b0, reset_window})
                s.count = '0;
            if (s.count < attempt_cap) begin
                s.mode  = rocr_pkg::MODE_WAIT_RECLOSE;
                s.timer = (s.count == '0) ? first_delay : later_delay;
            end
            else begin
                s.mode  = rocr_pkg::MODE_LOCKOUT;
                s.timer = '0;
            end
        endfunction

        function bit begin_overcurrent(inout relay_state_t s);
            if (clearing_len == '0) begin
                trip_now(s);
                return 1'b1;
            end
            s.mode  = rocr_pkg::MODE_CLEARING;
            s.timer = clearing_len;
            return 1'b0;
        endfunction

        function relay_result_t advance(inout relay_state_t s, input level_t cur);
            relay_result_t r;
            bit            over;
            bit            tripped;
            bit            reclosed;
            over     = (cur >= limit);
            tripped  = 1'b0;
            reclosed = 1'b0;
            if (s.since != rocr_pkg::SINCE_MAX)
                s.since = s.since + 1'b1;
            case (s.mode)
                rocr_pkg::MODE_NORMAL: begin
                    if (over)
                        tripped = begin_overcurrent(s);
                end
                rocr_pkg::MODE_CLEARING: begin
                    if (s.timer > 1)
                        s.timer = s.timer - 1'b1;
                    else if (over) begin
                        trip_now(s);
                        tripped = 1'b1;
                    end
                    else begin
                        s.mode  = rocr_pkg::MODE_NORMAL;
                        s.timer = '0;
                    end
                end
                rocr_pkg::MODE_WAIT_RECLOSE: begin
                    if (s.timer > 1)
                        s.timer = s.timer - 1'b1;
                    else begin
                        reclosed = 1'b1;
                        if (s.count != rocr_pkg::COUNT_MAX)
                            s.count = s.count + 1'b1;
                        s.since = '0;
                        s.mode  = rocr_pkg::MODE_NORMAL;
                        s.timer = '0;
                        // re-check the line right away after closing
                        if (over)
                            tripped = begin_overcurrent(s);
                    end
                end
                default: ;
            endcase
            r.breaker_open  = (s.mode == rocr_pkg::MODE_WAIT_RECLOSE) ||
                              (s.mode == rocr_pkg::MODE_LOCKOUT);
            r.trip_event    = tripped;
            r.reclose_event = reclosed;
            r.over_limit    = (s.mode == rocr_pkg::MODE_CLEARING);
            r.locked_out    = (s.mode == rocr_pkg::MODE_LOCKOUT);
            r.attempts_used = s.count;
            return r;
        endfunction

        function void note_input(level_t cur);
            relay_result_t r;
            r = advance(relay, cur);
            pending_q.push_back(r);
            trips         += r.trip_event;
            recloses      += r.reclose_event;
            lockout_ticks += r.locked_out;
        endfunction

        function bit would_lock(level_t cur);
            relay_state_t  probe;
            relay_result_t r;
            probe = relay;
            r = advance(probe, cur);
            return r.locked_out;
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] seen);
            if (seen !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check(relay_result_t seen);
            relay_result_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: result with no request outstanding: %b", $time, seen);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            compare_field("breaker_open", 4'(want.breaker_open), 4'(seen.breaker_open));
            compare_field("trip_event", 4'(want.trip_event), 4'(seen.trip_event));
            compare_field("reclose_event", 4'(want.reclose_event), 4'(seen.reclose_event));
            compare_field("over_limit", 4'(want.over_limit), 4'(seen.over_limit));
            compare_field("locked_out", 4'(want.locked_out), 4'(seen.locked_out));
            compare_field("attempts_used", want.attempts_used, seen.attempts_used);
        endfunction
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            in_valid      = 1'b0;
    logic                            in_ready;
    level_t                          current_level = '0;
    logic                            out_valid;
    logic                            out_ready     = 1'b0;
    logic                            breaker_open;
    logic                            trip_event;
    logic                            reclose_event;
    logic                            over_limit;
    logic                            locked_out;
    rocr_pkg::count_t                attempts_used;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [rocr_pkg::ADDR_W-1:0]     paddr         = '0;
    logic [rocr_pkg::DATA_W-1:0]     pwdata        = '0;
    logic [rocr_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    relay_scoreboard sb = new();
    int unsigned     src_idle_pct  = 34;
    int unsigned     sink_idle_pct = 84;
    int unsigned     cycle_count   = 0;

    reclosing_overcurrent_relay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .current_level (current_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .breaker_open  (breaker_open),
        .trip_event    (trip_event),
        .reclose_event (reclose_event),
        .over_limit    (over_limit),
        .locked_out    (locked_out),
        .attempts_used (attempts_used),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        relay_result_t seen;
        if (rst_n && out_valid && out_ready) begin
            seen.breaker_open  = breaker_open;
            seen.trip_event    = trip_event;
            seen.reclose_event = reclose_event;
            seen.over_limit    = over_limit;
            seen.locked_out    = locked_out;
            seen.attempts_used = attempts_used;
            sb.check(seen);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("reclosing_overcurrent_relay_test NOT OK");
            $finish;
        end
    end

    task automatic send_level(level_t cur);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        current_level <= cur;
        do @(posedge clk); while (!in_ready);
        sb.note_input(cur);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [rocr_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(level_t lim, rocr_pkg::tick_t clr, rocr_pkg::tick_t first,
                             rocr_pkg::tick_t later, rocr_pkg::count_t cap,
                             rocr_pkg::tick_t window);
        wait_drained();
        reg_write(rocr_pkg::REG_CURRENT_LIMIT, rocr_pkg::DATA_W'(lim));
        reg_write(rocr_pkg::REG_CLEARING_TICKS, rocr_pkg::DATA_W'(clr));
        reg_write(rocr_pkg::REG_FIRST_RECLOSE_TICKS, rocr_pkg::DATA_W'(first));
        reg_write(rocr_pkg::REG_LATER_RECLOSE_TICKS, rocr_pkg::DATA_W'(later));
        reg_write(rocr_pkg::REG_MAX_ATTEMPTS, rocr_pkg::DATA_W'(cap));
        reg_write(rocr_pkg::REG_ATTEMPT_RESET_TICKS, rocr_pkg::DATA_W'(window));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_setup();
        level_t           lim;
        rocr_pkg::tick_t  clr;
        rocr_pkg::count_t cap;
        lim = ($urandom_range(0, 9) == 0) ? rocr_pkg::LIMIT_RESET
                                          : level_t'($urandom_range(1, 65535));
        clr = ($urandom_range(0, 2) == 0) ? rocr_pkg::tick_t'(0)
                                          : rocr_pkg::tick_t'($urandom_range(1, 6));
        cap = ($urandom_range(0, 19) == 0) ? rocr_pkg::count_t'(0)
                                           : rocr_pkg::count_t'($urandom_range(1, 15));
        configure(lim, clr, rocr_pkg::tick_t'($urandom_range(0, 6)),
                  rocr_pkg::tick_t'($urandom_range(0, 6)),
                  cap, rocr_pkg::tick_t'($urandom_range(0, 12)));
    endtask

    // kind 0: overcurrent burst, kind 1: quiet line, otherwise anything
    function automatic level_t pick_level(int unsigned kind);
        int unsigned lim;
        int unsigned lo;
        int unsigned hi;
        lim = sb.limit;
        lo  = (lim > 2) ? lim - 2 : 0;
        hi  = (lim + 2 > 65535) ? 65535 : lim + 2;
        if (kind == 0)
            return ($urandom_range(0, 99) < 85) ? level_t'($urandom_range(lim, 65535))
                                                : level_t'($urandom_range(lo, hi));
        if (kind == 1)
            return (lim == 0) ? level_t'(0) : level_t'($urandom_range(0, lim - 1));
        case ($urandom_range(0, 3))
            0: return level_t'($urandom_range(0, 65535));
            1: return level_t'($urandom_range(lo, hi));
            2: return level_t'($urandom_range(lim, 65535));
            default: return (lim == 0) ? level_t'(0) : level_t'($urandom_range(0, lim - 1));
        endcase
    endfunction

    task automatic random_batch(int unsigned count);
        level_t      cur;
        int unsigned run_left;
        int unsigned run_kind;
        run_left = 0;
        run_kind = 2;
        repeat (count) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 10);
                run_kind = $urandom_range(0, 2);
            end
            run_left--;
            cur = pick_level(run_kind);
            // lockout is permanent: keep the line quiet rather than lock out early
            if (sb.would_lock(cur) && sb.limit != '0)
                cur = level_t'($urandom_range(0, sb.limit - 1));
            send_level(cur);
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        int unsigned phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stay below the threshold, any trip would lock out
        send_level(16'd0);
        send_level(16'd65534);

        // instant trips, reclose straight into a fault, later delay
        configure(16'd1000, 16'd0, 16'd2, 16'd1, 4'd15, 16'd0);
        send_level(16'd999);
        send_level(16'd1000);
        send_level(16'd65535);
        send_level(16'd65535);
        send_level(16'd0);
        send_level(16'd0);

        // clearing timer: fault held to expiry, then fault gone at expiry
        configure(16'd1000, 16'd2, 16'd2, 16'd1, 4'd15, 16'd0);
        send_level(16'd1000);
        send_level(16'd1000);
        send_level(16'd1000);
        send_level(16'd0);
        send_level(16'd0);
        send_level(16'd2000);
        send_level(16'd5);
        send_level(16'd5);

        // lower the attempt cap while a reclose is pending; it still goes ahead
        configure(16'd1000, 16'd2, 16'd5, 16'd1, 4'd15, 16'd0);
        send_level(16'd1000);
        send_level(16'd1000);
        send_level(16'd1000);
        configure(16'd1000, 16'd2, 16'd5, 16'd1, 4'd0, 16'd0);
        repeat (5) send_level(16'd0);
        send_level(16'd999);

        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 84 : 0;
            sink_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 34 : 0;
            repeat (4) begin
                random_setup();
                random_batch(110);
            end
        end

        // longer timers: clearing held to expiry, then a long wait for the reclose
        configure(16'd100, 16'd40, 16'd60, 16'd50, 4'd15, 16'd0);
        repeat (8) send_level(16'd0);
        repeat (41) send_level(level_t'($urandom_range(100, 65535)));
        repeat (70) send_level(level_t'($urandom_range(0, 99)));

        // every level over a zero threshold: climb through all attempts into lockout
        configure(16'd0, 16'd0, 16'd0, 16'd0, 4'd15, 16'd0);
        repeat (48) send_level(level_t'($urandom_range(0, 65535)));

        wait_drained();
        repeat (4) @(posedge clk);

        $display("Checked %0d results: %0d trips, %0d recloses, %0d locked-out ticks",
                 sb.checked, sb.trips, sb.recloses, sb.lockout_ticks);
        $display("Ran instant and timed trips, reclose into faults, long timers and lockout");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("reclosing_overcurrent_relay_test OK");
        else
            $display("reclosing_overcurrent_relay_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
design/rocr_pkg.sv
design/reclosing_overcurrent_relay.sv
test/reclosing_overcurrent_relay_test.sv
